FILE: rtl/bole_pkg.sv
// Package for the bounded ordered list engine: action and status codes,
// default sizes. No dependencies.
package bole_pkg;

  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefElemWidth = 32;

  localparam int unsigned ActionWidth = 4;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned PosWidth    = 5;
  localparam int unsigned FidxWidth   = 4;
  localparam int unsigned TotalWidth  = 5;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [ActionWidth-1:0] {
    ActPushBack   = 4'd0,
    ActPushFront  = 4'd1,
    ActPopBack    = 4'd2,
    ActPopFront   = 4'd3,
    ActSortedIns  = 4'd4,
    ActInsertAt   = 4'd5,
    ActRemoveAt   = 4'd6,
    ActReadAt     = 4'd7,
    ActFind       = 4'd8,
    ActIterReset  = 4'd9,
    ActIterNext   = 4'd10
  } action_e;

  typedef enum logic [StatusWidth-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;

  // Per-cell shift command, set for each cell of the chain.
  typedef enum logic [1:0] {
    ShHold  = 2'd0,
    ShRight = 2'd1,
    ShLeft  = 2'd2
  } shift_e;

  typedef struct packed {
    shift_e     shift;
    logic       load;
  } cell_ctrl_t;

endpackage

FILE: rtl/bole_if.sv
// Valid/ready channel interfaces for the list engine.
// Depends on bole_pkg for field widths.
interface bole_in_if import bole_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ActionWidth-1:0] action;
  logic [ValueWidth-1:0]  new_value;
  logic [PosWidth-1:0]    position;
  modport source (output valid, action, new_value, position, input ready);
  modport sink (input valid, action, new_value, position, output ready);
endinterface

interface bole_out_if import bole_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ValueWidth-1:0]  result_value;
  logic [FidxWidth-1:0]   found_index;
  logic                   found;
  logic [TotalWidth-1:0]  element_total;
  logic                   has_more;
  logic [StatusWidth-1:0] status;
  modport source (output valid, result_value, found_index, found, element_total,
                  has_more, status, input ready);
  modport sink (input valid, result_value, found_index, found, element_total,
                has_more, status, output ready);
endinterface

FILE: rtl/bole_cell.sv
// One storage cell of the list chain: holds an entry, shifts to either
// neighbor, and compares its entry with the broadcast key. Uses bole_pkg.
module bole_cell import bole_pkg::*; #(
  parameter int unsigned ElemWidth = DefElemWidth
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [ElemWidth-1:0] left_i,
  input  logic [ElemWidth-1:0] right_i,
  input  logic [ElemWidth-1:0] key_i,
  output logic [ElemWidth-1:0] value_o,
  output logic                 eq_o,
  output logic                 gt_o
);

  logic [ElemWidth-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = key_i;
    end else begin
      case (ctrl_i.shift)
        ShRight: value_d = left_i;
        ShLeft:  value_d = right_i;
        default: value_d = value_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign eq_o    = (value_q == key_i);
  assign gt_o    = (key_i < value_q);

endmodule

FILE: rtl/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: sequencer plus a chain of
// bole_cell entries. Depends on bole_pkg, bole_if and bole_cell.
//
//  channel | dir | transfer when        | payload
//  in_if   | in  | valid & ready        | action, new_value, position
//  out_if  | out | valid & ready        | result fields, status
//
// Each item is first registered in the idle state; in the execute state
// every cell compares against the key, then the shift is applied and the
// result is formed and registered. The input is ready again as soon as the
// result is registered. A stalled output holds the next item in the execute
// state until the waiting result is transferred.
// Reset clears the count, the iterator and the handshake state; cells
// are never cleared, since only live entries are read.
module bounded_ordered_list_engine import bole_pkg::*; #(
  parameter int unsigned Capacity  = DefCapacity,
  parameter int unsigned ElemWidth = DefElemWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bole_in_if.sink     in_if,
  bole_out_if.source  out_if
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic {StIdle, StExec} state_e;

  state_e                 state_q;
  logic [ActionWidth-1:0] act_q;
  logic [ElemWidth-1:0]   key_q;
  logic [PosWidth-1:0]    pos_q;
  logic [CntW-1:0]        cnt_q;
  logic [CntW-1:0]        iter_q;

  logic                   ovalid_q;
  logic [ValueWidth-1:0]  r_val_q;
  logic [FidxWidth-1:0]   r_fidx_q;
  logic                   r_fnd_q;
  logic [TotalWidth-1:0]  r_tot_q;
  logic                   r_more_q;
  logic [StatusWidth-1:0] r_st_q;

  logic [ElemWidth-1:0] cell_val [Capacity];
  logic [Capacity-1:0]  eq_v, gt_v;
  cell_ctrl_t           ctrl   [Capacity];

  // Slot for the final output transfer: free when empty or being taken.
  logic out_free;
  assign out_free     = !ovalid_q || out_if.ready;
  assign in_if.ready  = (state_q == StIdle);

  // Decode of the registered item against the current chain contents.
  logic                 do_place, do_take, wr_iter, rst_iter;
  logic [CntW-1:0]      at;
  logic [CntW-1:0]      cnt_d, iter_d;
  status_e              st;
  logic [ElemWidth-1:0] rv;
  logic [CntW-1:0]      sidx, fidx;
  logic                 fnd;
  logic [CntW-1:0]      pos_w;

  assign pos_w = CntW'(pos_q);

  // First-match searches over the cell flags (priority encoders).
  always_comb begin
    sidx = cnt_q;
    fidx = '0;
    fnd  = 1'b0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (CntW'(i) < cnt_q && gt_v[i]) sidx = CntW'(i);
      if (CntW'(i) < cnt_q && eq_v[i]) begin
        fidx = CntW'(i);
        fnd  = 1'b1;
      end
    end
  end

  always_comb begin
    do_place = 1'b0;
    do_take  = 1'b0;
    wr_iter  = 1'b0;
    rst_iter = 1'b0;
    at       = '0;
    st       = StOk;
    rv       = '0;
    case (act_q)
      ActPushBack, ActPushFront, ActSortedIns, ActInsertAt: begin
        case (act_q)
          ActPushBack:  at = cnt_q;
          ActSortedIns: at = sidx;
          ActInsertAt:  at = pos_w;
          default:      at = '0;
        endcase
        if (act_q == ActInsertAt && pos_q > PosWidth'(cnt_q)) st = StRange;
        else if (cnt_q >= CntW'(Capacity)) st = StFull;
        else do_place = 1'b1;
      end
      ActPopBack, ActPopFront, ActRemoveAt, ActReadAt: begin
        case (act_q)
          ActPopBack: at = cnt_q - 1'b1;
          ActPopFront: at = '0;
          default:    at = pos_w;
        endcase
        if (cnt_q == '0) st = StEmpty;
        else if ((act_q == ActRemoveAt || act_q == ActReadAt) &&
                 pos_q >= PosWidth'(cnt_q)) st = StRange;
        else begin
          rv      = cell_val[at[IdxW-1:0]];
          do_take = (act_q != ActReadAt);
        end
      end
      ActIterReset: rst_iter = 1'b1;
      ActIterNext: begin
        if (iter_q < cnt_q) begin
          rv      = cell_val[iter_q[IdxW-1:0]];
          wr_iter = 1'b1;
        end else begin
          st = StEmpty;
        end
      end
      default: ;
    endcase
  end

  assign cnt_d  = do_place ? cnt_q + 1'b1 : (do_take ? cnt_q - 1'b1 : cnt_q);
  assign iter_d = rst_iter ? '0 : (wr_iter ? iter_q + 1'b1 : iter_q);

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [ElemWidth-1:0] lft, rgt;
    logic                 exec;
    assign exec = (state_q == StExec) && out_free;
    assign lft  = (g == 0) ? cell_val[0] : cell_val[(g == 0) ? 0 : g - 1];
    assign rgt  = (g == Capacity - 1) ? cell_val[g] :
                  cell_val[(g == Capacity - 1) ? g : g + 1];
    always_comb begin
      ctrl[g].load  = exec && do_place && (CntW'(g) == at);
      ctrl[g].shift = ShHold;
      if (exec && do_place && CntW'(g) > at) ctrl[g].shift = ShRight;
      if (exec && do_take && CntW'(g) >= at) ctrl[g].shift = ShLeft;
    end
    bole_cell #(.ElemWidth(ElemWidth)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .left_i  (lft),
      .right_i (rgt),
      .key_i   (key_q),
      .value_o (cell_val[g]),
      .eq_o    (eq_v[g]),
      .gt_o    (gt_v[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      iter_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (out_if.ready) ovalid_q <= 1'b0;
          if (in_if.valid) state_q <= StExec;
        end
        StExec: begin
          if (out_free) begin
            state_q  <= StIdle;
            cnt_q    <= cnt_d;
            iter_q   <= iter_d;
            ovalid_q <= 1'b1;
          end
        end
        default: begin
          state_q  <= StIdle;
          ovalid_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      act_q <= in_if.action;
      key_q <= ElemWidth'(in_if.new_value);
      pos_q <= in_if.position;
    end
    if (state_q == StExec && out_free) begin
      r_val_q  <= ValueWidth'(rv);
      r_fidx_q <= (act_q == ActFind) ? FidxWidth'(fidx) : '0;
      r_fnd_q  <= (act_q == ActFind) && fnd;
      r_tot_q  <= TotalWidth'(cnt_d);
      r_more_q <= iter_d < cnt_d;
      r_st_q   <= st;
    end
  end

  assign out_if.valid         = ovalid_q;
  assign out_if.result_value  = r_val_q;
  assign out_if.found_index   = r_fidx_q;
  assign out_if.found         = r_fnd_q;
  assign out_if.element_total = r_tot_q;
  assign out_if.has_more      = r_more_q;
  assign out_if.status        = r_st_q;

  // The count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity)) else $error("count above capacity");
  // The count moves by at most one per item.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1 ||
    cnt_q == $past(cnt_q) - 1'b1) else $error("count jumped");
  // Input is never taken while an item is in execution.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StExec |-> !in_if.ready) else $error("overlapping items");

endmodule

FILE: tb/tb_bounded_ordered_list_engine.sv
// Testbench for the bounded ordered list engine: directed table, then random
// command mix, all results checked against a behavioral list predictor.
// Depends on bole_pkg, bole_if and the engine RTL.
module tb_bounded_ordered_list_engine import bole_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = DefCapacity;

  typedef struct packed {
    logic [ValueWidth-1:0]  value;
    logic [FidxWidth-1:0]   fidx;
    logic                   fnd;
    logic [TotalWidth-1:0]  total;
    logic                   more;
    status_e                st;
  } list_result_t;

  typedef struct {
    logic [ActionWidth-1:0] act;
    logic [ValueWidth-1:0]  val;
    logic [PosWidth-1:0]    pos;
    bit                     typed;
    list_result_t           res;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bole_in_if  in_if ();
  bole_out_if out_if ();

  bounded_ordered_list_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  logic [ValueWidth-1:0] shadow_list [Cap];
  int unsigned           shadow_count;
  int unsigned           shadow_iter;

  list_result_t pending_results [$];
  int unsigned  error_count;
  int unsigned  checked_count;
  int unsigned  sent_count;
  bit           quiet_mode;
  int unsigned  hold_cycles;

  function automatic status_e list_insert(int unsigned at, logic [ValueWidth-1:0] v);
    if (at > shadow_count) return StRange;
    if (shadow_count >= Cap) return StFull;
    for (int unsigned i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[at] = v;
    shadow_count++;
    return StOk;
  endfunction

  function automatic status_e list_take(int unsigned at, ref logic [ValueWidth-1:0] v);
    if (shadow_count == 0) return StEmpty;
    if (at >= shadow_count) return StRange;
    v = shadow_list[at];
    for (int unsigned i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return StOk;
  endfunction

  function automatic list_result_t predict_list_op(logic [ActionWidth-1:0] act,
                                                   logic [ValueWidth-1:0] nv,
                                                   logic [PosWidth-1:0] pos);
    list_result_t r;
    logic [ValueWidth-1:0] v;
    int unsigned i;
    v = '0;
    r = '0;
    r.st = StOk;
    case (act)
      ActPushBack:  r.st = list_insert(shadow_count, nv);
      ActPushFront: r.st = list_insert(0, nv);
      ActPopBack:   r.st = (shadow_count == 0) ? StEmpty : list_take(shadow_count - 1, v);
      ActPopFront:  r.st = list_take(0, v);
      ActSortedIns: begin
        for (i = 0; i < shadow_count; i++) if (nv < shadow_list[i]) break;
        r.st = list_insert(i, nv);
      end
      ActInsertAt:  r.st = list_insert(pos, nv);
      ActRemoveAt:  r.st = list_take(pos, v);
      ActReadAt: begin
        if (shadow_count == 0) r.st = StEmpty;
        else if (pos >= shadow_count) r.st = StRange;
        else v = shadow_list[pos];
      end
      ActFind: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == nv) begin
            r.fidx = i[FidxWidth-1:0];
            r.fnd = 1'b1;
            break;
          end
        end
      end
      ActIterReset: shadow_iter = 0;
      ActIterNext: begin
        if (shadow_iter < shadow_count) begin
          v = shadow_list[shadow_iter];
          shadow_iter++;
        end else begin
          r.st = StEmpty;
        end
      end
      default: ;
    endcase
    r.value = v;
    r.total = shadow_count[TotalWidth-1:0];
    r.more = shadow_iter < shadow_count;
    return r;
  endfunction

  // Sender.
  task automatic send_cmd(logic [ActionWidth-1:0] act, logic [ValueWidth-1:0] val,
                          logic [PosWidth-1:0] pos, bit typed, list_result_t typed_res);
    list_result_t r;
    while (!quiet_mode && $urandom_range(99) < 29) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.new_value <= val;
    in_if.position <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    r = predict_list_op(act, val, pos);
    if (typed && r !== typed_res) begin
      $display("%0t: table row disagrees with predictor: table %p predictor %p",
               $time, typed_res, r);
      error_count++;
    end
    pending_results.push_back(r);
    sent_count++;
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PosWidth-1:0] pick_pos();
    if ($urandom_range(9) == 0) return PosWidth'($urandom_range(31));
    return PosWidth'($urandom_range(shadow_count + 1));
  endfunction

  function automatic list_result_t typed_result(logic [ValueWidth-1:0] v, int unsigned total,
                                                bit more, status_e st);
    list_result_t r;
    r = '0;
    r.value = v;
    r.total = TotalWidth'(total);
    r.more = more;
    r.st = st;
    return r;
  endfunction

  cmd_row_t cmd_table [$];

  task automatic add_row(logic [ActionWidth-1:0] act, logic [ValueWidth-1:0] val,
                         logic [PosWidth-1:0] pos, bit typed, list_result_t res);
    cmd_row_t row;
    row.act = act; row.val = val; row.pos = pos; row.typed = typed; row.res = res;
    cmd_table.push_back(row);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    list_result_t none;
    logic [ActionWidth-1:0] act;
    int unsigned pick;
    none = '0;
    in_if.valid = 1'b0;
    in_if.action = ActPushBack;
    in_if.new_value = '0;
    in_if.position = '0;
    error_count = 0;
    checked_count = 0;
    sent_count = 0;
    quiet_mode = 1'b0;

    // Empty-list errors, then extremes, then fill to capacity.
    add_row(ActPopBack,   '0, '0, 1, typed_result('0, 0, 0, StEmpty));
    add_row(ActPopFront,  '0, '0, 1, typed_result('0, 0, 0, StEmpty));
    add_row(ActRemoveAt,  '0, '0, 1, typed_result('0, 0, 0, StEmpty));
    add_row(ActReadAt,    '0, 5'd31, 1, typed_result('0, 0, 0, StEmpty));
    add_row(ActIterNext,  '0, '0, 1, typed_result('0, 0, 0, StEmpty));
    add_row(ActInsertAt,  32'd5, 5'd1, 1, typed_result('0, 0, 0, StRange));
    add_row(ActFind,      '1, '0, 1, typed_result('0, 0, 0, StOk));
    add_row(4'd15,        '1, 5'd31, 1, typed_result('0, 0, 0, StOk));
    add_row(ActPushBack,  '1, '0, 1, typed_result('0, 1, 1, StOk));
    add_row(ActPushFront, '0, '0, 1, typed_result('0, 2, 1, StOk));
    add_row(ActSortedIns, 32'd7, '0, 0, none);
    add_row(ActSortedIns, 32'd7, '0, 0, none);
    add_row(ActInsertAt,  32'h5555_AAAA, 5'd2, 0, none);
    add_row(ActReadAt,    '0, 5'd4, 1, typed_result('1, 5, 1, StOk));
    add_row(ActReadAt,    '0, 5'd5, 1, typed_result('0, 5, 1, StRange));
    add_row(ActRemoveAt,  '0, 5'd5, 1, typed_result('0, 5, 1, StRange));
    add_row(ActFind,      32'd7, '0, 0, none);
    add_row(ActIterNext,  '0, '0, 1, typed_result('0, 5, 1, StOk));
    add_row(ActRemoveAt,  '0, 5'd2, 0, none);
    add_row(ActIterReset, '0, '0, 0, none);
    for (int i = 0; i < 12; i++) add_row(ActPushBack, i * 32'h1111_1111, '0, 0, none);
    add_row(ActPushFront, 32'd1, '0, 1, typed_result('0, 16, 1, StFull));
    add_row(ActInsertAt,  32'd1, 5'd17, 1, typed_result('0, 16, 1, StRange));
    add_row(ActPopBack,   '0, '0, 0, none);
    add_row(ActPopFront,  '0, '0, 1, typed_result('0, 14, 1, StOk));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cmd_table[i])
      send_cmd(cmd_table[i].act, cmd_table[i].val, cmd_table[i].pos,
               cmd_table[i].typed, cmd_table[i].res);

    // Random part: phases bias toward filling, draining, or a mix.
    for (int n = 0; n < 750; n++) begin
      if (n == 300) wait_drained();
      quiet_mode = (n >= 400 && n < 480);
      pick = $urandom_range(99);
      if ((n / 100) % 3 == 0)
        act = (pick < 60) ? ActionWidth'($urandom_range(ActSortedIns, ActPushBack))
                          : ActionWidth'($urandom_range(15));
      else if ((n / 100) % 3 == 1)
        act = (pick < 50) ? ActionWidth'($urandom_range(ActRemoveAt, ActPopBack))
                          : ActionWidth'($urandom_range(15));
      else
        act = ActionWidth'($urandom_range(15));
      if (act == ActPopBack && pick < 40) act = ActIterNext;
      if (act == ActSortedIns && pick < 30) act = ActPushFront;
      send_cmd(act, (act == ActFind && shadow_count != 0 && pick < 50)
                      ? shadow_list[$urandom_range(shadow_count - 1)] : pick_value(),
               pick_pos(), 0, none);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d list commands and checked %0d results, including full and empty",
             sent_count, checked_count);
    $display("stores, out-of-range positions and a long output stall.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, and a stretch with none.
  initial begin
    out_if.ready = 1'b0;
    hold_cycles = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (sent_count >= 100 && sent_count < 102 && hold_cycles == 0) begin
        out_if.ready <= 1'b0;
        while (hold_cycles < 60) begin
          @(posedge clk_i);
          hold_cycles++;
        end
      end
      out_if.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.value = out_if.result_value;
      got.fidx = out_if.found_index;
      got.fnd = out_if.found;
      got.total = out_if.element_total;
      got.more = out_if.has_more;
      got.st = status_e'(out_if.status);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer: expected none, actual %p", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.value !== want.value || got.fidx !== want.fidx || got.fnd !== want.fnd ||
            got.total !== want.total || got.more !== want.more || got.st !== want.st) begin
          $display("%0t: result mismatch: expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/bole_pkg.sv
rtl/bole_if.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine.sv
tb/tb_bounded_ordered_list_engine.sv
